/* hw/rtl/rngc_pkg.sv */
// shared types, constants and register codes for the range classifier
package rngc_pkg;

   localparam int unsigned ECHO_WIDTH  = 15;
   localparam int unsigned DIST_WIDTH  = 14;
   localparam int unsigned SUM_WIDTH   = 15;
   localparam int unsigned COUNT_WIDTH = 2;

   // distance = floor(echo_us * ECHO_SCALE / ECHO_DIVISOR), done as a reciprocal multiply
   localparam int unsigned ECHO_SCALE   = 80;
   localparam int unsigned ECHO_DIVISOR = 291;
   localparam int unsigned ECHO_SHIFT   = 24;
   localparam int unsigned ECHO_RECIP_WIDTH = 23;
   localparam logic [ECHO_RECIP_WIDTH-1:0] ECHO_RECIP = ECHO_RECIP_WIDTH'(
      ((64'(ECHO_SCALE) << ECHO_SHIFT) + 64'(ECHO_DIVISOR) - 64'd1) / 64'(ECHO_DIVISOR));

   // group mean, exact for any sum below 2**AVG_SHIFT
   localparam int unsigned AVERAGE_COUNT   = 3;
   localparam int unsigned AVG_SHIFT       = 17;
   localparam int unsigned AVG_RECIP_WIDTH = AVG_SHIFT + 1;
   localparam logic [AVG_RECIP_WIDTH-1:0] AVG_RECIP = AVG_RECIP_WIDTH'(
      ((64'd1 << AVG_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));

   localparam logic [DIST_WIDTH-1:0] MIN_DISTANCE_RESET      = DIST_WIDTH'(32);
   localparam logic [DIST_WIDTH-1:0] MAX_DISTANCE_RESET      = DIST_WIDTH'(6400);
   localparam logic [DIST_WIDTH-1:0] FAR_LIMIT_RESET         = DIST_WIDTH'(800);
   localparam logic [DIST_WIDTH-1:0] NEAR_LIMIT_RESET        = DIST_WIDTH'(320);
   localparam logic [DIST_WIDTH-1:0] BOUNDARY_DISTANCE_RESET = DIST_WIDTH'(160);

   typedef enum logic [2:0] {
      CSR_MIN_DISTANCE      = 3'd0,
      CSR_MAX_DISTANCE      = 3'd1,
      CSR_FAR_LIMIT         = 3'd2,
      CSR_NEAR_LIMIT        = 3'd3,
      CSR_BOUNDARY_DISTANCE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ZONE_FREE = 2'd0,
      ZONE_NEAR = 2'd1,
      ZONE_GRAB = 2'd2,
      ZONE_SHUT = 2'd3
   } zone_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] min_distance;
      logic [DIST_WIDTH-1:0] max_distance;
      logic [DIST_WIDTH-1:0] far_limit;
      logic [DIST_WIDTH-1:0] near_limit;
      logic [DIST_WIDTH-1:0] boundary_distance;
   } cfg_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      zone_type              zone;
      logic                  group_last;
      logic [SUM_WIDTH-1:0]  group_total;
   } dist_word_type;

endpackage

/* hw/rtl/rngc_csr.sv */
// configuration registers of the range classifier
module rngc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [2:0]                      csr_index,
   input  logic [rngc_pkg::DIST_WIDTH-1:0] csr_wdata,
   output rngc_pkg::cfg_type               cfg
);

   rngc_pkg::cfg_type cfg_ff;
   rngc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (rngc_pkg::csr_index_type'(csr_index))
            rngc_pkg::CSR_MIN_DISTANCE:      cfg_in.min_distance      = csr_wdata;
            rngc_pkg::CSR_MAX_DISTANCE:      cfg_in.max_distance      = csr_wdata;
            rngc_pkg::CSR_FAR_LIMIT:         cfg_in.far_limit         = csr_wdata;
            rngc_pkg::CSR_NEAR_LIMIT:        cfg_in.near_limit        = csr_wdata;
            rngc_pkg::CSR_BOUNDARY_DISTANCE: cfg_in.boundary_distance = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance      <= rngc_pkg::MIN_DISTANCE_RESET;
         cfg_ff.max_distance      <= rngc_pkg::MAX_DISTANCE_RESET;
         cfg_ff.far_limit         <= rngc_pkg::FAR_LIMIT_RESET;
         cfg_ff.near_limit        <= rngc_pkg::NEAR_LIMIT_RESET;
         cfg_ff.boundary_distance <= rngc_pkg::BOUNDARY_DISTANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/rngc_convert.sv */
// input register and echo time to distance conversion
module rngc_convert (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [rngc_pkg::ECHO_WIDTH-1:0] in_echo_us,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [rngc_pkg::DIST_WIDTH-1:0] out_distance
);

   localparam int unsigned PROD_WIDTH = rngc_pkg::ECHO_WIDTH + rngc_pkg::ECHO_RECIP_WIDTH;

   logic                            valid_ff;
   logic                            valid_in;
   logic [rngc_pkg::ECHO_WIDTH-1:0] echo_ff;
   logic [PROD_WIDTH-1:0]           product;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         echo_ff <= in_echo_us;
      end
   end

   // reciprocal multiply is exact over the whole 15 bit echo range
   assign product = PROD_WIDTH'(echo_ff) * PROD_WIDTH'(rngc_pkg::ECHO_RECIP);
   assign out_distance =
      product[rngc_pkg::ECHO_SHIFT +: rngc_pkg::DIST_WIDTH];
   assign out_valid = valid_ff;

endmodule

/* hw/rtl/rngc_validate.sv */
// range check with hold, zone classification and group accumulation
module rngc_validate (
   input  logic                            clock,
   input  logic                            reset,
   input  rngc_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [rngc_pkg::DIST_WIDTH-1:0] in_distance,
   output logic                            out_valid,
   input  logic                            out_ready,
   output rngc_pkg::dist_word_type         out_word
);

   logic                              valid_ff;
   logic                              valid_in;
   rngc_pkg::dist_word_type           word_ff;
   rngc_pkg::dist_word_type           word_in;
   logic [rngc_pkg::DIST_WIDTH-1:0]   held_ff;
   logic [rngc_pkg::DIST_WIDTH-1:0]   held_in;
   logic [rngc_pkg::SUM_WIDTH-1:0]    sum_ff;
   logic [rngc_pkg::SUM_WIDTH-1:0]    sum_in;
   logic [rngc_pkg::COUNT_WIDTH-1:0]  count_ff;
   logic [rngc_pkg::COUNT_WIDTH-1:0]  count_in;
   logic                              load;
   logic [rngc_pkg::DIST_WIDTH-1:0]   distance;
   logic [rngc_pkg::SUM_WIDTH-1:0]    total;
   logic [rngc_pkg::COUNT_WIDTH-1:0]  count_next;
   logic                              last;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      // out-of-range reading falls back to the last good distance
      if (in_distance < cfg.min_distance || in_distance > cfg.max_distance) begin
         distance = held_ff;
      end else begin
         distance = in_distance;
      end

      total      = sum_ff + rngc_pkg::SUM_WIDTH'(distance);
      count_next = count_ff + rngc_pkg::COUNT_WIDTH'(1);
      last       = count_next >= rngc_pkg::COUNT_WIDTH'(rngc_pkg::AVERAGE_COUNT);

      word_in.distance    = distance;
      word_in.group_last  = last;
      word_in.group_total = total;
      if (distance >= cfg.far_limit) begin
         word_in.zone = rngc_pkg::ZONE_FREE;
      end else if (distance >= cfg.near_limit) begin
         word_in.zone = rngc_pkg::ZONE_NEAR;
      end else if (distance != '0) begin
         word_in.zone = rngc_pkg::ZONE_GRAB;
      end else begin
         word_in.zone = rngc_pkg::ZONE_SHUT;
      end

      held_in  = held_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (load) begin
         held_in  = distance;
         sum_in   = last ? '0 : total;
         count_in = last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         held_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         held_ff  <= held_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* hw/rtl/rngc_average.sv */
// group mean, boundary flag and result register
module rngc_average (
   input  logic                            clock,
   input  logic                            reset,
   input  rngc_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  rngc_pkg::dist_word_type         in_word,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [rngc_pkg::DIST_WIDTH-1:0] out_distance_q4,
   output logic [1:0]                      out_zone,
   output logic                            out_average_ready,
   output logic [rngc_pkg::DIST_WIDTH-1:0] out_average_q4,
   output logic                            out_boundary_hit
);

   localparam int unsigned PROD_WIDTH = rngc_pkg::SUM_WIDTH + rngc_pkg::AVG_RECIP_WIDTH;

   logic                            valid_ff;
   logic                            valid_in;
   logic [rngc_pkg::DIST_WIDTH-1:0] distance_ff;
   rngc_pkg::zone_type              zone_ff;
   logic                            ready_ff;
   logic [rngc_pkg::DIST_WIDTH-1:0] average_ff;
   logic [rngc_pkg::DIST_WIDTH-1:0] average_in;
   logic                            hit_ff;
   logic                            hit_in;
   logic [PROD_WIDTH-1:0]           product;
   logic                            load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign product = PROD_WIDTH'(in_word.group_total) * PROD_WIDTH'(rngc_pkg::AVG_RECIP);

   always_comb begin
      average_in = '0;
      hit_in     = 1'b0;
      if (in_word.group_last) begin
         average_in = product[rngc_pkg::AVG_SHIFT +: rngc_pkg::DIST_WIDTH];
         hit_in     = (average_in <= cfg.boundary_distance) && (average_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         distance_ff <= in_word.distance;
         zone_ff     <= in_word.zone;
         ready_ff    <= in_word.group_last;
         average_ff  <= average_in;
         hit_ff      <= hit_in;
      end
   end

   assign out_valid         = valid_ff;
   assign out_distance_q4   = distance_ff;
   assign out_zone          = zone_ff;
   assign out_average_ready = ready_ff;
   assign out_average_q4    = average_ff;
   assign out_boundary_hit  = hit_ff;

endmodule

/* hw/rtl/ultrasonic_range_classifier_core.sv */
// echo width to distance, hold, zone and 3-word group average
// path: a request word is registered in the convert, validate and average
// stages in turn and is held on the rsp outputs until taken
// throughput: one word per cycle while rsp_ready is high; three stages
// hold one word each, stalling only when the next is full and not draining
// reset: thresholds return to defaults; held distance and group sum/count clear
module ultrasonic_range_classifier_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rngc_pkg::ECHO_WIDTH-1:0] req_echo_us,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rngc_pkg::DIST_WIDTH-1:0] rsp_distance_q4,
   output logic [1:0]                      rsp_zone,
   output logic                            rsp_average_ready,
   output logic [rngc_pkg::DIST_WIDTH-1:0] rsp_average_q4,
   output logic                            rsp_boundary_hit,
   input  logic                            csr_write_en,
   input  logic [2:0]                      csr_index,
   input  logic [rngc_pkg::DIST_WIDTH-1:0] csr_wdata
);

   rngc_pkg::cfg_type               cfg;
   logic                            conv_valid;
   logic                            conv_ready;
   logic [rngc_pkg::DIST_WIDTH-1:0] conv_distance;
   logic                            val_valid;
   logic                            val_ready;
   rngc_pkg::dist_word_type         val_word;

   rngc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rngc_convert u_convert (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_echo_us   (req_echo_us),
      .out_valid    (conv_valid),
      .out_ready    (conv_ready),
      .out_distance (conv_distance)
   );

   rngc_validate u_validate (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (conv_valid),
      .in_ready    (conv_ready),
      .in_distance (conv_distance),
      .out_valid   (val_valid),
      .out_ready   (val_ready),
      .out_word    (val_word)
   );

   rngc_average u_average (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (val_valid),
      .in_ready          (val_ready),
      .in_word           (val_word),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .out_distance_q4   (rsp_distance_q4),
      .out_zone          (rsp_zone),
      .out_average_ready (rsp_average_ready),
      .out_average_q4    (rsp_average_q4),
      .out_boundary_hit  (rsp_boundary_hit)
   );

endmodule

/* dv/testbench.sv */
// self-checking testbench for the ultrasonic range classifier core
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned US_TO_Q4_MUL = 80;
   localparam int unsigned US_TO_Q4_DIV = 291;
   localparam int unsigned GROUP_SIZE = 3;
   localparam int unsigned PIPE_DEPTH = 3;
   localparam int unsigned SEGMENTS = 3;
   localparam int unsigned RANDOM_WORDS = 46;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned TIMEOUT_NS = 2_000_000;
   localparam int unsigned CFG_BITS = $bits(rngc_pkg::cfg_type);
   localparam logic [rngc_pkg::ECHO_WIDTH-1:0] ECHO_TIMEOUT = '0;
   localparam logic [rngc_pkg::ECHO_WIDTH-1:0] ECHO_LONGEST = '1;
   localparam logic [rngc_pkg::DIST_WIDTH-1:0] DIST_TOP = '1;
   localparam logic [2:0] CSR_SPARE_FIRST = 3'(rngc_pkg::CSR_BOUNDARY_DISTANCE) + 3'd1;
   localparam logic [2:0] CSR_SPARE_LAST = '1;

   typedef struct packed {
      logic [rngc_pkg::DIST_WIDTH-1:0] distance;
      rngc_pkg::zone_type              zone;
      logic                            average_ready;
      logic [rngc_pkg::DIST_WIDTH-1:0] average;
      logic                            boundary_hit;
   } range_result_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [rngc_pkg::ECHO_WIDTH-1:0] req_echo_us = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [rngc_pkg::DIST_WIDTH-1:0] rsp_distance_q4;
   logic [1:0]                      rsp_zone;
   logic                            rsp_average_ready;
   logic [rngc_pkg::DIST_WIDTH-1:0] rsp_average_q4;
   logic                            rsp_boundary_hit;
   logic                            csr_write_en = 1'b0;
   logic [2:0]                      csr_index = '0;
   logic [rngc_pkg::DIST_WIDTH-1:0] csr_wdata = '0;

   // mirror of the block's thresholds and running state
   rngc_pkg::cfg_type               thresholds = '{rngc_pkg::MIN_DISTANCE_RESET,
      rngc_pkg::MAX_DISTANCE_RESET, rngc_pkg::FAR_LIMIT_RESET, rngc_pkg::NEAR_LIMIT_RESET,
      rngc_pkg::BOUNDARY_DISTANCE_RESET};
   logic [rngc_pkg::DIST_WIDTH-1:0] held_q4 = '0;
   logic [rngc_pkg::SUM_WIDTH-1:0]  group_total = '0;
   logic [1:0]                      group_fill = '0;

   range_result_type      pending_ranges[$];
   int unsigned           mismatch_count = 0;
   int unsigned           sender_idle_pct = 0;
   int unsigned           stall_pct = 0;

   ultrasonic_range_classifier_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_us       (req_echo_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance_q4   (rsp_distance_q4),
      .rsp_zone          (rsp_zone),
      .rsp_average_ready (rsp_average_ready),
      .rsp_average_q4    (rsp_average_q4),
      .rsp_boundary_hit  (rsp_boundary_hit),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

   function automatic range_result_type predict_range(
      input logic [rngc_pkg::ECHO_WIDTH-1:0] us);
      int unsigned      raw;
      range_result_type r;
      r = '0;
      raw = (32'(us) * US_TO_Q4_MUL) / US_TO_Q4_DIV;
      // out-of-window readings fall back to the last accepted distance
      if (raw < thresholds.min_distance || raw > thresholds.max_distance)
         r.distance = held_q4;
      else
         r.distance = rngc_pkg::DIST_WIDTH'(raw);
      held_q4 = r.distance;
      if (r.distance >= thresholds.far_limit)
         r.zone = rngc_pkg::ZONE_FREE;
      else if (r.distance >= thresholds.near_limit)
         r.zone = rngc_pkg::ZONE_NEAR;
      else if (r.distance != '0)
         r.zone = rngc_pkg::ZONE_GRAB;
      else
         r.zone = rngc_pkg::ZONE_SHUT;
      group_total = group_total + rngc_pkg::SUM_WIDTH'(r.distance);
      group_fill = group_fill + 2'd1;
      if (group_fill >= GROUP_SIZE) begin
         r.average_ready = 1'b1;
         r.average = rngc_pkg::DIST_WIDTH'(group_total / GROUP_SIZE);
         r.boundary_hit = (r.average <= thresholds.boundary_distance) && (r.average != '0);
         group_total = '0;
         group_fill = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_results
      range_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ranges.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result word, dist %0d zone %0d", $time,
                        rsp_distance_q4, rsp_zone);
         end else begin
            want = pending_ranges.pop_front();
            if (rsp_distance_q4 !== want.distance || rsp_zone !== want.zone ||
                rsp_average_ready !== want.average_ready ||
                rsp_average_q4 !== want.average || rsp_boundary_hit !== want.boundary_hit) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch exp dist %0d zone %0d rdy %0b avg %0d hit %0b",
                            " / got dist %0d zone %0d rdy %0b avg %0d hit %0b"},
                           $time, want.distance, want.zone, want.average_ready,
                           want.average, want.boundary_hit,
                           rsp_distance_q4, rsp_zone, rsp_average_ready,
                           rsp_average_q4, rsp_boundary_hit);
            end
         end
      end
   end

   task automatic send_echo(input logic [rngc_pkg::ECHO_WIDTH-1:0] us);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_echo_us <= us;
      do @(posedge clock); while (!req_ready);
      pending_ranges.push_back(predict_range(us));
   endtask

   // stop sending and let every outstanding word come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index,
                            input logic [rngc_pkg::DIST_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         rngc_pkg::CSR_MIN_DISTANCE:      thresholds.min_distance = data;
         rngc_pkg::CSR_MAX_DISTANCE:      thresholds.max_distance = data;
         rngc_pkg::CSR_FAR_LIMIT:         thresholds.far_limit = data;
         rngc_pkg::CSR_NEAR_LIMIT:        thresholds.near_limit = data;
         rngc_pkg::CSR_BOUNDARY_DISTANCE: thresholds.boundary_distance = data;
         default: ;
      endcase
   endtask

   task automatic program_thresholds(input rngc_pkg::cfg_type t);
      write_csr(rngc_pkg::CSR_MIN_DISTANCE, t.min_distance);
      write_csr(rngc_pkg::CSR_MAX_DISTANCE, t.max_distance);
      write_csr(rngc_pkg::CSR_FAR_LIMIT, t.far_limit);
      write_csr(rngc_pkg::CSR_NEAR_LIMIT, t.near_limit);
      write_csr(rngc_pkg::CSR_BOUNDARY_DISTANCE, t.boundary_distance);
      csr_write_en <= 1'b0;
   endtask

   // reset thresholds: rejects before anything is held, window and zone edges
   task automatic test_default_thresholds();
      logic [rngc_pkg::ECHO_WIDTH-1:0] echoes[12] = '{ECHO_TIMEOUT, 15'd116, 15'd117,
         15'd1163, 15'd1164, 15'd2909, 15'd2910, 15'd23280, 15'd23284, 15'd30000,
         ECHO_LONGEST, 15'd1};
      foreach (echoes[i]) send_echo(echoes[i]);
   endtask

   // near limit above far limit, so the near zone can never be picked; zero accepted is shut
   task automatic test_zone_order();
      logic [rngc_pkg::ECHO_WIDTH-1:0] echoes[6] = '{ECHO_TIMEOUT, 15'd400, 15'd20,
         ECHO_LONGEST, 15'd3, 15'd364};
      wait_for_results();
      program_thresholds('{'0, DIST_TOP, rngc_pkg::DIST_WIDTH'(100),
         rngc_pkg::DIST_WIDTH'(5000), DIST_TOP});
      foreach (echoes[i]) send_echo(echoes[i]);
   endtask

   // zero average never flags, an average equal to the boundary does
   task automatic test_boundary_flag();
      logic [rngc_pkg::ECHO_WIDTH-1:0] echoes[6] = '{ECHO_TIMEOUT, ECHO_TIMEOUT,
         ECHO_TIMEOUT, 15'd582, 15'd582, 15'd583};
      wait_for_results();
      program_thresholds('{'0, DIST_TOP, rngc_pkg::FAR_LIMIT_RESET,
         rngc_pkg::NEAR_LIMIT_RESET, rngc_pkg::BOUNDARY_DISTANCE_RESET});
      while (group_fill != '0) send_echo(ECHO_TIMEOUT);
      foreach (echoes[i]) send_echo(echoes[i]);
   endtask

   // writes past the last register must not alias onto a real one
   task automatic test_spare_index();
      wait_for_results();
      write_csr(CSR_SPARE_FIRST, '0);
      write_csr(CSR_SPARE_FIRST + 3'd1, '0);
      write_csr(CSR_SPARE_LAST, DIST_TOP);
      csr_write_en <= 1'b0;
      send_echo(15'd1164);
      send_echo(15'd30000);
   endtask

   task automatic run_random_phase(input int unsigned send_pct, input int unsigned stall);
      rngc_pkg::cfg_type               t;
      int unsigned                     lo, hi, target, raw_us, mode;
      logic [rngc_pkg::ECHO_WIDTH-1:0] us;
      repeat (SEGMENTS) begin
         wait_for_results();
         sender_idle_pct = send_pct;
         stall_pct = stall;
         case ($urandom_range(0, 7))
            0: t = '0;
            1: t = '1;
            2: t = '{rngc_pkg::MIN_DISTANCE_RESET, rngc_pkg::MAX_DISTANCE_RESET,
                     rngc_pkg::FAR_LIMIT_RESET, rngc_pkg::NEAR_LIMIT_RESET,
                     rngc_pkg::BOUNDARY_DISTANCE_RESET};
            3: t = CFG_BITS'({$urandom, $urandom, $urandom});
            default: begin
               t.min_distance = rngc_pkg::DIST_WIDTH'($urandom_range(0, 400));
               t.max_distance = rngc_pkg::DIST_WIDTH'($urandom_range(2000, 8248));
               t.far_limit = rngc_pkg::DIST_WIDTH'($urandom_range(0, 8248));
               t.near_limit = rngc_pkg::DIST_WIDTH'($urandom_range(0, 8248));
               t.boundary_distance = rngc_pkg::DIST_WIDTH'($urandom_range(0, 1200));
            end
         endcase
         program_thresholds(t);
         repeat (RANDOM_WORDS) begin
            lo = thresholds.min_distance;
            hi = (thresholds.max_distance > lo) ? thresholds.max_distance : lo;
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
               us = ECHO_TIMEOUT;
            end else if (mode <= 2) begin
               us = rngc_pkg::ECHO_WIDTH'($urandom);
            end else begin
               if (mode == 3) begin
                  // small distances so group averages land near the boundary
                  target = $urandom_range(lo,
                     (thresholds.boundary_distance > lo) ? thresholds.boundary_distance : lo);
               end else if (mode == 4) begin
                  case ($urandom_range(0, 4))
                     0: target = thresholds.min_distance;
                     1: target = thresholds.max_distance;
                     2: target = thresholds.far_limit;
                     3: target = thresholds.near_limit;
                     default: target = thresholds.boundary_distance;
                  endcase
                  target = target + $urandom_range(0, 4);
                  target = (target > 2) ? target - 2 : 0;
               end else begin
                  target = $urandom_range(lo, hi);
               end
               // smallest echo reaching the target distance, jittered by one either way
               raw_us = (target * US_TO_Q4_DIV + US_TO_Q4_MUL - 1) / US_TO_Q4_MUL;
               raw_us = raw_us + $urandom_range(0, 2);
               raw_us = (raw_us != 0) ? raw_us - 1 : 0;
               if (raw_us > ECHO_LONGEST)
                  raw_us = ECHO_LONGEST;
               us = rngc_pkg::ECHO_WIDTH'(raw_us);
            end
            send_echo(us);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_thresholds();
      test_zone_order();
      test_boundary_flag();
      test_spare_index();
      run_random_phase(0, 0);
      run_random_phase(58, 0);
      run_random_phase(0, 58);
      run_random_phase(24, 24);
      wait_for_results();
      repeat (PIPE_DEPTH + 5) @(posedge clock);
      if (mismatch_count == 0 && pending_ranges.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/rngc_pkg.sv
hw/rtl/rngc_csr.sv
hw/rtl/rngc_convert.sv
hw/rtl/rngc_validate.sv
hw/rtl/rngc_average.sv
hw/rtl/ultrasonic_range_classifier_core.sv
dv/testbench.sv
